@@ hdl/lfu_pkg.sv @@
// Package: shared types and constants for the LFU cache table.
`timescale 1ns / 1ps
package lfu_pkg;
	localparam int SLOTS_DEF = 16;
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CNT_W = 32;
	localparam int AGE_W = 48;
	localparam logic [VAL_W-1:0] MISS_VALUE = '1;
	localparam logic [CNT_W-1:0] COUNT_MAX = '1;
	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	typedef struct packed {
		logic cmd;
		logic signed [KEY_W-1:0] lookup_key;
		logic signed [VAL_W-1:0] write_value;
	} req_t;

	typedef struct packed {
		logic found;
		logic signed [VAL_W-1:0] read_value;
		logic stored;
		logic evicted;
		logic signed [KEY_W-1:0] evicted_key;
	} rsp_t;

	typedef struct packed {
		logic start;
		logic step;
		logic commit;
	} ctl_t;

	typedef struct packed {
		logic last;
	} sts_t;
endpackage

@@ hdl/lfu_cache_table.sv @@
// Top level: LFU key-value table with least-recent tie break.
// channel | valid     | stall      | payload
// request | in_valid  | in_stall   | in_data (req_t)
// result  | out_valid | out_stall  | out_data (rsp_t)
// Each request is accepted, then scanned over the slot table (one slot read per
// cycle), then committed: the commit edge updates the table and loads the
// result register.
// Reset empties the table, clears the age counter and sets capacity to 16.
// The next request is taken right after commit; while a result stalls, that
// request scans and then holds its commit until the result is taken.
`timescale 1ns / 1ps
module lfu_cache_table #(
	parameter int SLOTS = lfu_pkg::SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [lfu_pkg::CAP_W-1:0] cfg_wdata,
	input  logic in_valid,
	output logic in_stall,
	input  lfu_pkg::req_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output lfu_pkg::rsp_t out_data
);
	import lfu_pkg::*;
	logic [CAP_W-1:0] capacity_q;
	req_t req_q;
	ctl_t ctl;
	sts_t sts;
	logic req_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) capacity_q <= CAPACITY_RESET;
		else if (cfg_we) capacity_q <= cfg_wdata;
	end

	always_ff @(posedge clk) begin
		if (req_load) req_q <= in_data;
	end

	lfu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .ctl(ctl),
		.req_load(req_load)
	);

	lfu_datapath #(.SLOTS(SLOTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .capacity_q(capacity_q), .req(req_q),
		.ctl(ctl), .sts(sts), .rsp(out_data)
	);
endmodule

@@ hdl/lfu_datapath.sv @@
// Datapath: slot storage, scan for key match, victim, free slot and occupancy.
`timescale 1ns / 1ps
module lfu_datapath #(
	parameter int SLOTS = lfu_pkg::SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [lfu_pkg::CAP_W-1:0] capacity_q,
	input  lfu_pkg::req_t req,
	input  lfu_pkg::ctl_t ctl,
	output lfu_pkg::sts_t sts,
	output lfu_pkg::rsp_t rsp
);
	import lfu_pkg::*;
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int OW = $clog2(SLOTS + 1);

	logic [SLOTS-1:0] valid_q;
	logic [KEY_W-1:0] key_mem [SLOTS];
	logic [VAL_W-1:0] val_mem [SLOTS];
	logic [CNT_W-1:0] cnt_mem [SLOTS];
	logic [AGE_W-1:0] age_mem [SLOTS];
	logic [AGE_W-1:0] age_ctr_q;

	logic [IW-1:0] idx_q;
	logic          hit_q, vic_ok_q, free_ok_q;
	logic [IW-1:0] hit_idx_q, vic_idx_q, free_idx_q;
	logic [CNT_W-1:0] vic_cnt_q;
	logic [AGE_W-1:0] vic_age_q;
	logic [OW-1:0] occ_q;

	logic [KEY_W-1:0] rk;
	logic [VAL_W-1:0] rv;
	logic [CNT_W-1:0] rc;
	logic [AGE_W-1:0] ra;
	logic rvalid;
	logic better;

	always_comb begin
		rk = key_mem[idx_q];
		rv = val_mem[idx_q];
		rc = cnt_mem[idx_q];
		ra = age_mem[idx_q];
		rvalid = valid_q[idx_q];
		better = !vic_ok_q || (rc < vic_cnt_q) || (rc == vic_cnt_q && ra < vic_age_q);
	end

	assign sts.last = (idx_q == IW'(SLOTS - 1));

	logic [OW-1:0] eff;
	logic full, do_evict, do_fill, do_store;
	logic [IW-1:0] fill_idx;
	logic [SLOTS-1:0] valid_set, valid_clr;
	always_comb begin
		eff = (32'(capacity_q) > 32'(SLOTS)) ? OW'(SLOTS) : OW'(capacity_q);
		full = (occ_q >= eff);
		do_evict = full && vic_ok_q;
		do_fill = !full || do_evict;
		fill_idx = (free_ok_q && !(do_evict && vic_idx_q < free_idx_q)) ?
			free_idx_q : vic_idx_q;
		if (full && !do_evict) fill_idx = free_idx_q;
		do_store = !hit_q && (req.cmd == CMD_PUT) && do_fill && (free_ok_q || do_evict);
		valid_set = '0;
		valid_clr = '0;
		if (!hit_q && req.cmd == CMD_PUT) begin
			if (do_evict) valid_clr[vic_idx_q] = 1'b1;
			if (do_store) valid_set[fill_idx] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			age_ctr_q <= '0;
			idx_q <= '0;
			hit_q <= 1'b0;
			vic_ok_q <= 1'b0;
			free_ok_q <= 1'b0;
			occ_q <= '0;
		end else if (ctl.start) begin
			idx_q <= '0;
			hit_q <= 1'b0;
			vic_ok_q <= 1'b0;
			free_ok_q <= 1'b0;
			occ_q <= '0;
		end else if (ctl.step) begin
			if (rvalid) begin
				occ_q <= occ_q + OW'(1);
				if (rk == req.lookup_key && !hit_q) begin
					hit_q <= 1'b1;
					hit_idx_q <= idx_q;
				end
				if (better) begin
					vic_ok_q <= 1'b1;
					vic_idx_q <= idx_q;
					vic_cnt_q <= rc;
					vic_age_q <= ra;
				end
			end else if (!free_ok_q) begin
				free_ok_q <= 1'b1;
				free_idx_q <= idx_q;
			end
			if (!sts.last) idx_q <= idx_q + IW'(1);
		end else if (ctl.commit) begin
			valid_q <= (valid_q & ~valid_clr) | valid_set;
			if (hit_q || do_store) age_ctr_q <= age_ctr_q + AGE_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			if (hit_q) begin
				if (req.cmd == CMD_PUT) val_mem[hit_idx_q] <= req.write_value;
				if (cnt_mem[hit_idx_q] != COUNT_MAX)
					cnt_mem[hit_idx_q] <= cnt_mem[hit_idx_q] + CNT_W'(1);
				age_mem[hit_idx_q] <= age_ctr_q;
			end else if (do_store) begin
				key_mem[fill_idx] <= req.lookup_key;
				val_mem[fill_idx] <= req.write_value;
				cnt_mem[fill_idx] <= CNT_W'(1);
				age_mem[fill_idx] <= age_ctr_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			rsp.found <= hit_q;
			rsp.read_value <= (hit_q && req.cmd == CMD_GET) ? val_mem[hit_idx_q] : MISS_VALUE;
			rsp.stored <= (req.cmd == CMD_PUT) &&
				(hit_q || (do_fill && (free_ok_q || do_evict)));
			rsp.evicted <= (req.cmd == CMD_PUT) && !hit_q && do_evict;
			rsp.evicted_key <= ((req.cmd == CMD_PUT) && !hit_q && do_evict) ?
				key_mem[vic_idx_q] : '0;
		end
	end
endmodule

@@ hdl/lfu_ctrl.sv @@
// Controller: request handshake and scan sequencing.
`timescale 1ns / 1ps
module lfu_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  lfu_pkg::sts_t sts,
	output lfu_pkg::ctl_t ctl,
	output logic req_load
);
	import lfu_pkg::*;
	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;
	state_t state_q;
	logic out_free;

	assign out_free = !out_valid || !out_stall;
	assign in_stall = (state_q != S_IDLE);
	assign req_load = (state_q == S_IDLE) && in_valid;
	assign ctl.start = req_load;
	assign ctl.step = (state_q == S_SCAN);
	assign ctl.commit = (state_q == S_DONE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (ctl.commit) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_SCAN;
				S_SCAN: if (sts.last) state_q <= S_DONE;
				S_DONE: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ verif/tb_lfu_cache_table.sv @@
// Testbench: LFU cache table checked against a cycle-free LFU table model.
`timescale 1ns / 1ps
module tb_lfu_cache_table;
	import lfu_pkg::*;

	localparam int NSLOT = 16;
	localparam int N_RAND = 1830;
	localparam longint LIMIT = 1500000;

	class lfu_scoreboard;
		rsp_t pending[$];
		logic valid_q[NSLOT];
		logic [31:0] key_q[NSLOT];
		logic [31:0] val_q[NSLOT];
		logic [31:0] cnt_q[NSLOT];
		logic [47:0] age_q[NSLOT];
		logic [47:0] age_ctr;
		logic [4:0] cap;
		int errors;
		int checked;

		function new();
			errors = 0;
			checked = 0;
			age_ctr = '0;
			cap = CAPACITY_RESET;
			for (int i = 0; i < NSLOT; i++) begin
				valid_q[i] = 1'b0;
				key_q[i] = '0;
				val_q[i] = '0;
				cnt_q[i] = '0;
				age_q[i] = '0;
			end
		endfunction

		function void touch(int s);
			if (cnt_q[s] != COUNT_MAX) cnt_q[s]++;
			age_q[s] = age_ctr;
			age_ctr++;
		endfunction

		function void note_request(req_t r);
			rsp_t e;
			int s;
			int occ;
			int eff;
			int v;
			s = -1;
			occ = 0;
			v = -1;
			e = '0;
			e.read_value = MISS_VALUE;
			for (int i = 0; i < NSLOT; i++) begin
				if (valid_q[i]) occ++;
				if (s < 0 && valid_q[i] && key_q[i] == r.lookup_key) s = i;
			end
			if (r.cmd == CMD_GET) begin
				if (s >= 0) begin
					e.found = 1'b1;
					e.read_value = val_q[s];
					touch(s);
				end
			end else if (s >= 0) begin
				e.found = 1'b1;
				e.stored = 1'b1;
				val_q[s] = r.write_value;
				touch(s);
			end else begin
				eff = (cap > NSLOT) ? NSLOT : cap;
				if (occ >= eff) begin
					for (int i = 0; i < NSLOT; i++)
						if (valid_q[i] && (v < 0 || cnt_q[i] < cnt_q[v] ||
							(cnt_q[i] == cnt_q[v] && age_q[i] < age_q[v]))) v = i;
					if (v >= 0) begin
						e.evicted = 1'b1;
						e.evicted_key = key_q[v];
						valid_q[v] = 1'b0;
					end
				end
				if (occ < eff || e.evicted) begin
					for (int i = 0; i < NSLOT; i++)
						if (!valid_q[i] && !e.stored) begin
							valid_q[i] = 1'b1;
							key_q[i] = r.lookup_key;
							val_q[i] = r.write_value;
							cnt_q[i] = 1;
							age_q[i] = age_ctr;
							age_ctr++;
							e.stored = 1'b1;
						end
				end
			end
			pending.push_back(e);
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch %s: got %h want %h", what, got, want);
			errors++;
		endtask

		task check_result(rsp_t g);
			rsp_t e;
			if (pending.size() == 0) begin
				report("unexpected result", 0, 0);
			end else begin
				e = pending.pop_front();
				checked++;
				if (g.found !== e.found) report("found", g.found, e.found);
				if (g.read_value !== e.read_value)
					report("read_value", g.read_value, e.read_value);
				if (g.stored !== e.stored) report("stored", g.stored, e.stored);
				if (g.evicted !== e.evicted) report("evicted", g.evicted, e.evicted);
				if (g.evicted_key !== e.evicted_key)
					report("evicted_key", g.evicted_key, e.evicted_key);
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CAP_W-1:0] cfg_wdata;
	logic in_valid;
	logic in_stall;
	req_t in_data;
	logic out_valid;
	logic out_stall;
	rsp_t out_data;

	lfu_scoreboard sb;
	longint cycles;
	int sent;
	bit done_sending;
	int ostall_left;

	lfu_cache_table uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) sb.check_result(out_data);
			if (ostall_left > 0) begin
				ostall_left <= ostall_left - 1;
				out_stall <= 1'b1;
			end else if (out_valid && !out_stall) begin
				ostall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task send(logic cmd, logic [31:0] k, logic [31:0] v, bit pace);
		int gap;
		gap = pace ? (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19)) : 0;
		repeat (gap) @(posedge clk);
		in_valid <= 1'b1;
		in_data <= '{cmd: cmd, lookup_key: k, write_value: v};
		do @(posedge clk); while (in_stall);
		sb.note_request(in_data);
		sent++;
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (NSLOT + 8) @(posedge clk);
	endtask

	task set_capacity(logic [4:0] c);
		cfg_we <= 1'b1;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.cap = c;
	endtask

	function logic [31:0] pick_key(int pool);
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return 32'h8000_0000 + $urandom_range(0, 3);
			2: return 32'h7fff_fffc + $urandom_range(0, 3);
			default: return $urandom_range(0, pool);
		endcase
	endfunction

	initial begin
		logic [4:0] caps[7];
		int pool;
		caps = '{5'd16, 5'd0, 5'd1, 5'd31, 5'd4, 5'd17, 5'd9};
		sb = new();
		cycles = 0;
		sent = 0;
		ostall_left = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(CMD_GET, 32'd5, 32'd0, 0);
		send(CMD_PUT, 32'h8000_0000, 32'h7fff_ffff, 0);
		send(CMD_PUT, 32'h7fff_ffff, 32'h8000_0000, 0);
		send(CMD_PUT, 32'hffff_ffff, 32'hffff_ffff, 0);
		send(CMD_PUT, 32'd0, 32'd0, 0);
		send(CMD_GET, 32'h8000_0000, 32'h1234_5678, 0);
		send(CMD_PUT, 32'h7fff_ffff, 32'h5555_aaaa, 0);
		for (int i = 1; i <= 13; i++) send(CMD_PUT, 32'(i), 32'(i * 7), 1);
		send(CMD_PUT, 32'd100, 32'd1, 0);
		send(CMD_PUT, 32'd101, 32'd2, 0);
		send(CMD_GET, 32'd100, 32'd0, 0);
		drain();
		set_capacity(5'd0);
		send(CMD_PUT, 32'd200, 32'd3, 0);
		send(CMD_GET, 32'd200, 32'd0, 0);
		drain();

		for (int ph = 0; ph < 7; ph++) begin
			set_capacity(caps[ph]);
			pool = (caps[ph] < 3) ? 4 : caps[ph] + caps[ph] / 2;
			for (int i = 0; i < N_RAND / 7; i++) begin
				if (i == N_RAND / 14) begin
					while (sb.pending.size() != 0) @(posedge clk);
				end
				if (caps[ph] == 5'd0 && i == 10) begin
					drain();
					set_capacity(5'd16);
					for (int j = 0; j < 16; j++) send(CMD_PUT, 32'(j), $urandom(), 1);
					drain();
					set_capacity(5'd0);
				end
				send(1'($urandom_range(0, 1)), pick_key(pool), $urandom(), 1);
			end
			drain();
		end

		drain();
		$display("sent %0d requests over capacities 0, 1, 4, 9, 16, 17, 31", sent);
		$display("checked %0d results, %0d mismatches", sb.checked, sb.errors);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
